### design/assert_macros.svh
// Assertion helpers for the modulator RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define SPWM_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("modulator assertion failed");
`define SPWM_ASSERT_IMPL(lbl, clk, rstn, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (pre) |-> (post)) \
    else $error("modulator implication failed");
`else
`define SPWM_ASSERT(lbl, clk, rstn, prop)
`define SPWM_ASSERT_IMPL(lbl, clk, rstn, pre, post)
`endif
`endif

### design/spwm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package spwm_pkg;
  localparam int ANGLE_BITS_DEF   = 16;
  localparam int VOLTAGE_BITS_DEF = 16;
  localparam int CORDIC_STEPS     = 20;
  localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;
  localparam logic signed [53:0] SQRT3_Q16   = 54'sd113512;

  localparam logic [1:0] REG_SUPPLY = 2'd0;
  localparam logic [1:0] REG_LIMIT  = 2'd1;
  localparam logic [1:0] REG_PERIOD = 2'd2;

  localparam logic [15:0] SUPPLY_RST = 16'd12000;
  localparam logic [15:0] LIMIT_RST  = 16'd12000;
  localparam logic [15:0] PERIOD_RST = 16'd1000;

  // arctangent of 2^-i, 2^32 per turn
  function automatic logic signed [33:0] atan_turn(input int i);
    logic signed [33:0] r;
    unique case (i)
      0: r = 34'sd536870912;
      1: r = 34'sd316933406;
      2: r = 34'sd167458907;
      3: r = 34'sd85004756;
      4: r = 34'sd42667331;
      5: r = 34'sd21354465;
      6: r = 34'sd10679838;
      7: r = 34'sd5340245;
      8: r = 34'sd2670163;
      9: r = 34'sd1335087;
      10: r = 34'sd667544;
      11: r = 34'sd333772;
      12: r = 34'sd166886;
      13: r = 34'sd83443;
      14: r = 34'sd41722;
      15: r = 34'sd20861;
      16: r = 34'sd10430;
      17: r = 34'sd5215;
      18: r = 34'sd2608;
      default: r = 34'sd1304;
    endcase
    return r;
  endfunction

  // round half up from Q2.30 to Q1.15 and saturate
  function automatic logic signed [15:0] to_q15(input logic signed [33:0] v);
    logic signed [34:0] s;
    logic signed [19:0] r;
    s = 35'(v) + 35'sd16384;
    r = 20'(s >>> 15);
    if (r > 20'sd32767) return 16'sh7fff;
    else if (r < -20'sd32768) return 16'sh8000;
    else return r[15:0];
  endfunction
endpackage
`default_nettype wire

### design/sinusoidal_pwm_voltage_modulator.sv
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
// Sinusoidal PWM modulator: q-axis voltage command plus electrical angle in,
// three PWM compare values out.
// Input: a transaction is taken at every clock edge with start high; busy is
// always low, so a new command may enter in every cycle.
// Output: valid_o pulses for one cycle with duty_a_o/duty_b_o/duty_c_o; the
// receiver must take it in that cycle. Results leave in input order.
// Throughput is one transaction per cycle. The depth of the pipeline is set by the
// 20-step CORDIC pipeline and the 17-step restoring divider per phase that
// divides by the supply voltage.
// Configuration: cfg_we_i/cfg_idx_i/cfg_wdata_i write supply voltage (0),
// phase voltage limit (1) and PWM period (2); other indexes are dropped.
// Write them only while no transaction is in flight.
// Reset: clears the pipeline valid bits and loads the default registers
// (12000 mV, 12000 mV, period 1000). A supply of zero gives zero duties.
module sinusoidal_pwm_voltage_modulator #(
  parameter int ANGLE_BITS   = spwm_pkg::ANGLE_BITS_DEF,
  parameter int VOLTAGE_BITS = spwm_pkg::VOLTAGE_BITS_DEF
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic               cfg_we_i,
  input  wire logic [1:0]         cfg_idx_i,
  input  wire logic [15:0]        cfg_wdata_i,
  input  wire logic signed [15:0] voltage_command_i,
  input  wire logic [15:0]        electrical_angle_i,
  output logic                    valid_o,
  output logic [15:0]             duty_a_o,
  output logic [15:0]             duty_b_o,
  output logic [15:0]             duty_c_o
);
  import spwm_pkg::*;

  localparam int LAT = 44;
  localparam int DIV_STEPS = 17;
  localparam logic [15:0] VMASK16 =
    (VOLTAGE_BITS >= 16) ? 16'hffff : 16'((32'd1 << VOLTAGE_BITS) - 32'd1);
  localparam logic [26:0] VMASK27 = 27'((64'd1 << VOLTAGE_BITS) - 64'd1);
  localparam logic [26:0] VSPAN27 = 27'(64'd1 << VOLTAGE_BITS);
  localparam logic [31:0] AMASK = 32'((64'd1 << ANGLE_BITS) - 64'd1);

  logic [15:0] supply_q, limit_q, period_q;
  logic [LAT-1:0] v_q;

  assign busy = 1'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      supply_q <= SUPPLY_RST;
      limit_q  <= LIMIT_RST;
      period_q <= PERIOD_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_SUPPLY: supply_q <= cfg_wdata_i & VMASK16;
        REG_LIMIT:  limit_q  <= cfg_wdata_i & VMASK16;
        REG_PERIOD: period_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      v_q <= {v_q[LAT-2:0], start & ~busy};
    end
  end

  // ---- input stage: command clamp, angle fold ----
  logic [26:0]        raw;
  logic signed [26:0] cmd_ext, cmd2, sup27;
  logic signed [17:0] cmd_d;
  logic [31:0]        ang32, ang_f;
  logic               flip_d;

  always_comb begin
    raw     = 27'(electrical_angle_i) & 27'd0;
    raw     = 27'({11'd0, voltage_command_i}) & VMASK27;
    cmd_ext = raw[VOLTAGE_BITS-1] ? $signed(raw - VSPAN27) : $signed(raw);
    cmd2    = cmd_ext <<< 1;
    sup27   = $signed(27'(supply_q));
    if (cmd2 > sup27) cmd_d = 18'(sup27);
    else if (cmd2 < -sup27) cmd_d = 18'(-sup27);
    else cmd_d = 18'(cmd2);
    ang32  = (32'(electrical_angle_i) & AMASK) << (32 - ANGLE_BITS);
    flip_d = (ang32[31:30] == 2'd1) || (ang32[31:30] == 2'd2);
    ang_f  = flip_d ? ang32 + 32'h8000_0000 : ang32;
  end

  logic signed [33:0] cx_q [0:CORDIC_STEPS];
  logic signed [33:0] cy_q [0:CORDIC_STEPS];
  logic signed [33:0] cz_q [0:CORDIC_STEPS];
  logic               fl_q [0:CORDIC_STEPS];
  logic signed [17:0] cc_q [0:CORDIC_STEPS];

  always_ff @(posedge clk_i) begin
    cx_q[0] <= CORDIC_GAIN;
    cy_q[0] <= '0;
    cz_q[0] <= 34'($signed(ang_f));
    fl_q[0] <= flip_d;
    cc_q[0] <= cmd_d;
  end

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cordic
    always_ff @(posedge clk_i) begin
      fl_q[i+1] <= fl_q[i];
      cc_q[i+1] <= cc_q[i];
      if (!cz_q[i][33]) begin
        cx_q[i+1] <= cx_q[i] - (cy_q[i] >>> i);
        cy_q[i+1] <= cy_q[i] + (cx_q[i] >>> i);
        cz_q[i+1] <= cz_q[i] - atan_turn(i);
      end else begin
        cx_q[i+1] <= cx_q[i] + (cy_q[i] >>> i);
        cy_q[i+1] <= cy_q[i] - (cx_q[i] >>> i);
        cz_q[i+1] <= cz_q[i] + atan_turn(i);
      end
    end
  end

  // ---- sine/cosine, rotation, phase split ----
  logic signed [15:0] sin_q, cos_q;
  logic signed [17:0] cmd_s_q;
  logic signed [35:0] alpha_q, beta_q, alpha2_q;
  logic signed [53:0] s3raw_q;

  always_ff @(posedge clk_i) begin
    sin_q    <= to_q15(fl_q[CORDIC_STEPS] ? -cy_q[CORDIC_STEPS] : cy_q[CORDIC_STEPS]);
    cos_q    <= to_q15(fl_q[CORDIC_STEPS] ? -cx_q[CORDIC_STEPS] : cx_q[CORDIC_STEPS]);
    cmd_s_q  <= cc_q[CORDIC_STEPS];
    alpha_q  <= -(36'(cmd_s_q) * 36'(sin_q));
    beta_q   <= 36'(cmd_s_q) * 36'(cos_q);
    alpha2_q <= alpha_q;
    s3raw_q  <= 54'(beta_q) * SQRT3_Q16;
  end

  logic signed [39:0] s3b, mid, lim40;
  logic signed [39:0] ph [3];
  logic [32:0]        u_d [3];

  always_comb begin
    s3b   = 40'((s3raw_q + 54'sd32768) >>> 16);
    mid   = $signed(40'(supply_q)) <<< 16;
    lim40 = $signed(40'(limit_q)) <<< 17;
    ph[0] = 40'(alpha2_q) + 40'(alpha2_q) + mid;
    ph[1] = s3b - 40'(alpha2_q) + mid;
    ph[2] = -40'(alpha2_q) - s3b + mid;
    for (int l = 0; l < 3; l++) begin
      if (ph[l] < 40'sd0) u_d[l] = '0;
      else if (ph[l] > lim40) u_d[l] = 33'(lim40);
      else u_d[l] = 33'(ph[l]);
    end
  end

  logic [32:0] u_q [3];
  always_ff @(posedge clk_i) begin
    for (int l = 0; l < 3; l++) u_q[l] <= u_d[l];
  end

  // ---- duty = floor(u * period / 2^17 / supply), capped at period ----
  logic [31:0] dn_q   [3][0:DIV_STEPS];
  logic [15:0] drem_q [3][0:DIV_STEPS];
  logic [16:0] dq_q   [3][0:DIV_STEPS];
  logic        dovf_q [3][0:DIV_STEPS];
  logic [48:0] prod   [3];

  always_comb begin
    for (int l = 0; l < 3; l++) prod[l] = 49'(u_q[l]) * 49'(period_q);
  end

  always_ff @(posedge clk_i) begin
    for (int l = 0; l < 3; l++) begin
      dn_q[l][0]   <= prod[l][48:17];
      drem_q[l][0] <= 16'(prod[l][48:34]);
      dq_q[l][0]   <= '0;
      dovf_q[l][0] <= {1'b0, prod[l][48:17]} >= {supply_q, 17'd0};
    end
  end

  for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
    for (genvar l = 0; l < 3; l++) begin : g_lane
      logic [16:0] t;
      assign t = {drem_q[l][k], dn_q[l][k][DIV_STEPS-1-k]};
      always_ff @(posedge clk_i) begin
        dn_q[l][k+1]   <= dn_q[l][k];
        dovf_q[l][k+1] <= dovf_q[l][k];
        if (t >= {1'b0, supply_q}) begin
          drem_q[l][k+1] <= 16'(t - {1'b0, supply_q});
          dq_q[l][k+1]   <= {dq_q[l][k][15:0], 1'b1};
        end else begin
          drem_q[l][k+1] <= t[15:0];
          dq_q[l][k+1]   <= {dq_q[l][k][15:0], 1'b0};
        end
      end
    end
  end

  logic [15:0] duty_q [3];
  always_ff @(posedge clk_i) begin
    for (int l = 0; l < 3; l++) begin
      if (supply_q == '0) duty_q[l] <= '0;
      else if (dovf_q[l][DIV_STEPS] || dq_q[l][DIV_STEPS] > 17'(period_q))
        duty_q[l] <= period_q;
      else duty_q[l] <= dq_q[l][DIV_STEPS][15:0];
    end
  end

  assign valid_o  = v_q[LAT-1];
  assign duty_a_o = duty_q[0];
  assign duty_b_o = duty_q[1];
  assign duty_c_o = duty_q[2];

  `SPWM_ASSERT_IMPL(a_duty_le_period, clk_i, rst_ni, valid_o, (duty_a_o <= period_q) && (duty_b_o <= period_q) && (duty_c_o <= period_q))
  `SPWM_ASSERT_IMPL(a_zero_supply, clk_i, rst_ni, valid_o && (supply_q == '0), (duty_a_o == '0) && (duty_b_o == '0) && (duty_c_o == '0))
  `SPWM_ASSERT_IMPL(a_valid_origin, clk_i, rst_ni, valid_o, $past(v_q[0], LAT-1))
  `SPWM_ASSERT(a_never_busy, clk_i, rst_ni, !busy)
endmodule
`default_nettype wire

### sim/sinusoidal_pwm_voltage_modulator_tb.sv
`timescale 1ns / 1ps
module sinusoidal_pwm_voltage_modulator_tb;
  import spwm_pkg::*;

  typedef struct packed {
    logic signed [15:0] cmd;
    logic [15:0]        angle;
  } command_t;

  typedef struct packed {
    logic [15:0] a;
    logic [15:0] b;
    logic [15:0] c;
  } duties_t;

  localparam int WATCHDOG_LIMIT = 3000;
  localparam int DRAIN_CYCLES   = 60;
  localparam logic [1:0] REG_UNUSED = 2'd3;

  logic clk_i, rst_ni;
  logic start, busy;
  logic cfg_we_i;
  logic [1:0] cfg_idx_i;
  logic [15:0] cfg_wdata_i;
  logic signed [15:0] voltage_command_i;
  logic [15:0] electrical_angle_i;
  logic valid_o;
  logic [15:0] duty_a_o, duty_b_o, duty_c_o;

  command_t pending_cmds[$];
  duties_t  expected_duties[$];
  logic [15:0] supply_mv, limit_mv, period_cnt;
  int  errors;
  int  stall_pct;
  bit  took_last;
  int  quiet_cycles;

  sinusoidal_pwm_voltage_modulator uut (
    .clk_i(clk_i), .rst_ni(rst_ni), .start(start), .busy(busy),
    .cfg_we_i(cfg_we_i), .cfg_idx_i(cfg_idx_i), .cfg_wdata_i(cfg_wdata_i),
    .voltage_command_i(voltage_command_i), .electrical_angle_i(electrical_angle_i),
    .valid_o(valid_o), .duty_a_o(duty_a_o), .duty_b_o(duty_b_o), .duty_c_o(duty_c_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  function automatic longint round_q15(longint v);
    longint r;
    r = (v + 16384) >>> 15;
    if (r > 32767) r = 32767;
    if (r < -32768) r = -32768;
    return r;
  endfunction

  function automatic logic [15:0] phase_duty(longint v, longint lim, longint den,
                                             longint per);
    longint d;
    if (v < 0) v = 0;
    if (v > lim) v = lim;
    d = (v * per) / den;
    if (d > per) d = per;
    return d[15:0];
  endfunction

  function automatic duties_t modulate(command_t it);
    longint atan_tab[20] = '{536870912, 316933406, 167458907, 85004756, 42667331,
                             21354465, 10679838, 5340245, 2670163, 1335087,
                             667544, 333772, 166886, 83443, 41722,
                             20861, 10430, 5215, 2608, 1304};
    duties_t r;
    logic [31:0] a;
    bit flip;
    longint x, y, z, dx, dy, s, c, cmd, sup, alpha, beta, s3b, mid, den, lim;
    r = '0;
    if (supply_mv == 0) return r;
    sup = longint'(supply_mv);
    cmd = 2 * longint'(it.cmd);
    if (cmd > sup) cmd = sup;
    if (cmd < -sup) cmd = -sup;
    // rotate second and third quadrant by a half turn, negate afterwards
    a = {it.angle, 16'h0000};
    flip = (a[31:30] == 2'd1) || (a[31:30] == 2'd2);
    if (flip) a = a + 32'h8000_0000;
    z = longint'(signed'(a));
    x = 652032874;
    y = 0;
    for (int i = 0; i < 20; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx; y += dy; z -= atan_tab[i];
      end else begin
        x += dx; y -= dy; z += atan_tab[i];
      end
    end
    if (flip) begin
      x = -x; y = -y;
    end
    s = round_q15(y);
    c = round_q15(x);
    alpha = -(cmd * s);
    beta = cmd * c;
    s3b = (beta * 113512 + 32768) >>> 16;
    mid = sup * 65536;
    den = sup <<< 17;
    lim = longint'(limit_mv) <<< 17;
    r.a = phase_duty(2 * alpha + mid, lim, den, longint'(period_cnt));
    r.b = phase_duty(s3b - alpha + mid, lim, den, longint'(period_cnt));
    r.c = phase_duty(-alpha - s3b + mid, lim, den, longint'(period_cnt));
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [15:0] got, logic [15:0] want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $time);
    errors++;
  endtask

  // driver
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      start <= 1'b0;
    end else if (!start || took_last) begin
      if (pending_cmds.size() > 0 && $urandom_range(99) >= stall_pct) begin
        command_t it;
        it = pending_cmds.pop_front();
        voltage_command_i <= it.cmd;
        electrical_angle_i <= it.angle;
        start <= 1'b1;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // monitor and checker
  always @(posedge clk_i) begin
    if (rst_ni) begin
      duties_t want;
      took_last = start && !busy;
      if (took_last)
        expected_duties.push_back(modulate('{voltage_command_i, electrical_angle_i}));
      if (valid_o) begin
        if (expected_duties.size() == 0) begin
          report_mismatch("unexpected transaction duty_a", duty_a_o, 16'd0);
        end else begin
          want = expected_duties.pop_front();
          if (duty_a_o !== want.a) report_mismatch("duty_a", duty_a_o, want.a);
          if (duty_b_o !== want.b) report_mismatch("duty_b", duty_b_o, want.b);
          if (duty_c_o !== want.c) report_mismatch("duty_c", duty_c_o, want.c);
        end
      end
      quiet_cycles = (took_last || valid_o) ? 0 : quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  task automatic write_reg(logic [1:0] idx, logic [15:0] val);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= val;
    case (idx)
      REG_SUPPLY: supply_mv = val;
      REG_LIMIT:  limit_mv = val;
      REG_PERIOD: period_cnt = val;
      default: ;
    endcase
  endtask

  task automatic set_config(logic [15:0] sup, logic [15:0] lim, logic [15:0] per);
    write_reg(REG_SUPPLY, sup);
    write_reg(REG_LIMIT, lim);
    write_reg(REG_PERIOD, per);
    // unknown index must be dropped
    write_reg(REG_UNUSED, 16'($urandom));
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic drain;
    while (pending_cmds.size() > 0 || start || expected_duties.size() > 0)
      @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic queue_random(int n);
    command_t it;
    for (int i = 0; i < n; i++) begin
      it.angle = 16'($urandom);
      if ($urandom_range(3) == 0) it.cmd = 16'($urandom);
      else it.cmd = 16'(int'($urandom_range(2 * supply_mv + 2)) - int'(supply_mv));
      pending_cmds.push_back(it);
    end
  endtask

  initial begin
    logic signed [15:0] dir_cmd[8] = '{16'sh8000, 16'sd32767, 16'sd0, 16'sd1, -16'sd1,
                                       16'sd3000, -16'sd3000, 16'sd6000};
    logic [15:0] dir_ang[4] = '{16'h0000, 16'h4000, 16'h8000, 16'hffff};
    logic [15:0] cfgs[7][3] = '{'{16'd24000, 16'd20000, 16'd1000},
                                '{16'd0, 16'd12000, 16'd1000},
                                '{16'hffff, 16'hffff, 16'hffff},
                                '{16'd1, 16'd1, 16'd1},
                                '{16'd24000, 16'd10000, 16'd0},
                                '{16'd48000, 16'd40000, 16'd4095},
                                '{16'd5000, 16'hffff, 16'd20000}};
    errors = 0;
    stall_pct = 23;
    took_last = 0;
    quiet_cycles = 0;
    rst_ni = 1'b0;
    start = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = '0;
    cfg_wdata_i = '0;
    voltage_command_i = '0;
    electrical_angle_i = '0;
    supply_mv = SUPPLY_RST;
    limit_mv = LIMIT_RST;
    period_cnt = PERIOD_RST;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // corners of command and angle at reset settings
    for (int i = 0; i < 8; i++)
      for (int j = 0; j < 3; j++)
        pending_cmds.push_back('{dir_cmd[i], dir_ang[(i + j) % 4]});
    drain();

    for (int p = 0; p < 7; p++) begin
      set_config(cfgs[p][0], cfgs[p][1], cfgs[p][2]);
      stall_pct = (p == 2) ? 0 : 23;
      queue_random(150);
      drain();
    end
    set_config(16'($urandom), 16'($urandom), 16'($urandom));
    stall_pct = 23;
    queue_random(150);
    drain();
    set_config(16'($urandom_range(2000, 30000)), 16'($urandom),
               16'($urandom_range(1, 2000)));
    queue_random(326);
    drain();

    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end
endmodule
